[design/mavg_pkg.sv]
package mavg_pkg;

  // sizing
  localparam int MAX_WINDOW      = 64;
  localparam int SAMPLE_BITS     = 16;
  localparam int AXES            = 3;
  localparam int WINDOW_REG_BITS = 7;
  localparam int WINDOW_RESET    = 8;

  localparam int POS_BITS    = $clog2(MAX_WINDOW);
  localparam int WIN_BITS    = $clog2(MAX_WINDOW + 1);
  localparam int SUM_BITS    = SAMPLE_BITS + POS_BITS;
  localparam int RING_BITS   = AXES * SAMPLE_BITS;
  localparam int CMP_BITS    = (WIN_BITS > WINDOW_REG_BITS) ? WIN_BITS : WINDOW_REG_BITS;
  localparam int WINDOW_INIT = (WINDOW_RESET > MAX_WINDOW) ? MAX_WINDOW : WINDOW_RESET;

  // serial divider, one quotient bit per cycle
  localparam int DIV_CNT_BITS = $clog2(SUM_BITS);
  localparam int DIV_LAST     = SUM_BITS - 1;

  typedef struct packed {
    logic start;
    logic clear;
    logic take;
  } lane_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } lane_status_t;

endpackage

[design/moving_average_three_axis.sv]
// three-axis moving average over a window of the last window_len samples
//
// input channel: in_valid / in_stall with sample_x, sample_y, sample_z; a word
// is taken at a rising edge where in_valid is high and in_stall is low
// output channel: out_valid / out_stall with avg_x, avg_y, avg_z, each the
// window sum divided by window_len, truncated toward zero
// config: cfg_wr_en / cfg_wr_data write window_len (0 reads as 1, values
// above 64 as 64); any write clears the sample ring, sums and position. The
// user must have it issued only while no word is in flight; block doesn't enforce it
//
// each word passes ring read, sum update, the 22-step serial divider that
// each axis lane runs (one quotient bit per cycle) and sign fixup; a new
// word is taken only once the lanes pass the last result to the output register.
// the result sits in an output register, so a new word is taken while the
// receiver stalls; the lanes finish and hold until that register frees up
// reset (rst, synchronous): window_len = 8, ring reads as zero, no output
module moving_average_three_axis (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_wr_en,
  input  logic [mavg_pkg::WINDOW_REG_BITS-1:0]    cfg_wr_data,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [mavg_pkg::SAMPLE_BITS-1:0] sample_x,
  input  logic signed [mavg_pkg::SAMPLE_BITS-1:0] sample_y,
  input  logic signed [mavg_pkg::SAMPLE_BITS-1:0] sample_z,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [mavg_pkg::SAMPLE_BITS-1:0] avg_x,
  output logic signed [mavg_pkg::SAMPLE_BITS-1:0] avg_y,
  output logic signed [mavg_pkg::SAMPLE_BITS-1:0] avg_z
);
  import mavg_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_BUSY = 3'b100
  } top_state_t;

  top_state_t                 state, state_next;
  logic [WIN_BITS-1:0]        window;
  logic [WIN_BITS-1:0]        win_sat;
  logic [POS_BITS-1:0]        pos;
  logic [WIN_BITS:0]          pos_inc;
  logic                       accept;
  logic                       load;
  logic                       all_done;
  lane_ctrl_t                 lane_ctrl;
  lane_status_t               lane_status [AXES];
  logic signed [SAMPLE_BITS-1:0] smp      [AXES];
  logic signed [SAMPLE_BITS-1:0] oldest   [AXES];
  logic signed [SAMPLE_BITS-1:0] lane_avg [AXES];
  logic [RING_BITS-1:0]       ring_wdata;
  logic [RING_BITS-1:0]       ring_rdata;

  // handshake: one word in flight through the lanes at a time
  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;

  // merge: all lanes run in lockstep, result moves out when the register frees
  always_comb begin
    all_done = 1'b1;
    for (int a = 0; a < AXES; a++) begin
      all_done = all_done & lane_status[a].done;
    end
  end
  assign load = (state == S_BUSY) && all_done && (!out_valid || !out_stall);

  // window register write with saturation into 1 .. MAX_WINDOW
  always_comb begin
    if (cfg_wr_data == '0) begin
      win_sat = WIN_BITS'(1);
    end else if (CMP_BITS'(cfg_wr_data) > CMP_BITS'(MAX_WINDOW)) begin
      win_sat = WIN_BITS'(MAX_WINDOW);
    end else begin
      win_sat = WIN_BITS'(cfg_wr_data);
    end
  end

  // next write position, wraps at the window length
  assign pos_inc = (WIN_BITS + 1)'(pos) + 1'b1;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_READ;
        end
      end
      S_READ: state_next = S_BUSY;
      S_BUSY: begin
        if (load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      window    <= WIN_BITS'(WINDOW_INIT);
      pos       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        window <= win_sat;
        pos    <= '0;
      end else if (state == S_READ) begin
        pos <= (pos_inc >= (WIN_BITS + 1)'(window)) ? '0 : pos_inc[POS_BITS-1:0];
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // capture the word; the ring slot it replaces is read in the same edge
  always_ff @(posedge clk) begin
    if (accept) begin
      smp[0] <= sample_x;
      smp[1] <= sample_y;
      smp[2] <= sample_z;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (load) begin
      avg_x <= lane_avg[0];
      avg_y <= lane_avg[1];
      avg_z <= lane_avg[2];
    end
  end

  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      ring_wdata[a*SAMPLE_BITS +: SAMPLE_BITS] = smp[a];
      oldest[a] = ring_rdata[a*SAMPLE_BITS +: SAMPLE_BITS];
    end
  end

  // sample ring: read old entry on accept, overwrite it in the next cycle (S_READ)
  mavg_ring u_ring (
    .clk     (clk),
    .rst     (rst),
    .clear   (cfg_wr_en),
    .rd_en   (accept),
    .rd_addr (pos),
    .wr_en   (state == S_READ),
    .wr_addr (pos),
    .wr_data (ring_wdata),
    .rd_data (ring_rdata)
  );

  assign lane_ctrl.start = (state == S_READ);
  assign lane_ctrl.clear = cfg_wr_en;
  assign lane_ctrl.take  = load;

  // one lane per axis: running sum and serial divide
  for (genvar g = 0; g < AXES; g++) begin : g_lane
    mavg_lane u_lane (
      .clk    (clk),
      .rst    (rst),
      .ctrl   (lane_ctrl),
      .window (window),
      .sample (smp[g]),
      .oldest (oldest[g]),
      .status (lane_status[g]),
      .avg    (lane_avg[g])
    );
  end

  ap_accept_read: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_READ)
    else $error("accepted word did not move to ring read");

  ap_lane_start: assert property (@(posedge clk) disable iff (rst)
    state == S_READ |=> lane_status[0].busy && !lane_status[0].done)
    else $error("lane did not start after ring read");

  ap_lockstep: assert property (@(posedge clk) disable iff (rst)
    lane_status[0].done == lane_status[1].done &&
    lane_status[0].done == lane_status[2].done)
    else $error("axis lanes out of step");

  ap_pos_range: assert property (@(posedge clk) disable iff (rst)
    WIN_BITS'(pos) < window)
    else $error("write position outside window");

  ap_load_valid: assert property (@(posedge clk) disable iff (rst)
    load |=> out_valid)
    else $error("loaded result not presented");

endmodule

[design/mavg_ring.sv]
module mavg_ring (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          clear,
  input  logic                          rd_en,
  input  logic [mavg_pkg::POS_BITS-1:0]  rd_addr,
  input  logic                          wr_en,
  input  logic [mavg_pkg::POS_BITS-1:0]  wr_addr,
  input  logic [mavg_pkg::RING_BITS-1:0] wr_data,
  output logic [mavg_pkg::RING_BITS-1:0] rd_data
);
  import mavg_pkg::*;

  logic [RING_BITS-1:0]  mem [MAX_WINDOW];
  logic [RING_BITS-1:0]  mem_q;
  logic [MAX_WINDOW-1:0] filled;
  logic                  hit;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  // entries never written since the last clear read as zero
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      filled <= '0;
    end else if (wr_en) begin
      filled[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit <= 1'b0;
    end else if (rd_en) begin
      hit <= filled[rd_addr];
    end
  end

  assign rd_data = hit ? mem_q : '0;

endmodule

[design/mavg_lane.sv]
module mavg_lane (
  input  logic                                clk,
  input  logic                                rst,
  input  mavg_pkg::lane_ctrl_t                ctrl,
  input  logic [mavg_pkg::WIN_BITS-1:0]        window,
  input  logic signed [mavg_pkg::SAMPLE_BITS-1:0] sample,
  input  logic signed [mavg_pkg::SAMPLE_BITS-1:0] oldest,
  output mavg_pkg::lane_status_t              status,
  output logic signed [mavg_pkg::SAMPLE_BITS-1:0] avg
);
  import mavg_pkg::*;

  typedef enum logic [4:0] {
    L_IDLE = 5'b00001,
    L_ABS  = 5'b00010,
    L_DIV  = 5'b00100,
    L_SIGN = 5'b01000,
    L_DONE = 5'b10000
  } lane_state_t;

  lane_state_t               state, state_next;
  logic signed [SUM_BITS-1:0] sum;
  logic [SUM_BITS-1:0]       quot;
  logic [SUM_BITS-1:0]       quot_signed;
  logic [WIN_BITS-1:0]       rem;
  logic [WIN_BITS:0]         trial;
  logic [WIN_BITS:0]         trial_sub;
  logic                      fits;
  logic                      neg;
  logic [DIV_CNT_BITS-1:0]   cnt;

  // dividend shifts out of quot at the top while quotient bits shift in
  always_comb begin
    trial       = {rem, quot[SUM_BITS-1]};
    fits        = trial >= {1'b0, window};
    trial_sub   = trial - {1'b0, window};
    quot_signed = neg ? (~quot + 1'b1) : quot;
  end

  always_comb begin
    state_next = state;
    case (state)
      L_IDLE: begin
        if (ctrl.start) begin
          state_next = L_ABS;
        end
      end
      L_ABS:  state_next = L_DIV;
      L_DIV: begin
        if (cnt == DIV_CNT_BITS'(DIV_LAST)) begin
          state_next = L_SIGN;
        end
      end
      L_SIGN: state_next = L_DONE;
      L_DONE: begin
        if (ctrl.take) begin
          state_next = L_IDLE;
        end
      end
      default: state_next = L_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
      sum   <= '0;
    end else begin
      state <= state_next;
      if (ctrl.clear) begin
        sum <= '0;
      end else if (ctrl.start && state == L_IDLE) begin
        // running window sum: drop the overwritten entry, add the new one
        sum <= sum - SUM_BITS'(oldest) + SUM_BITS'(sample);
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      L_ABS: begin
        quot <= sum[SUM_BITS-1] ? $unsigned(-sum) : $unsigned(sum);
        neg  <= sum[SUM_BITS-1];
        rem  <= '0;
        cnt  <= '0;
      end
      L_DIV: begin
        quot <= {quot[SUM_BITS-2:0], fits};
        rem  <= fits ? trial_sub[WIN_BITS-1:0] : trial[WIN_BITS-1:0];
        cnt  <= cnt + 1'b1;
      end
      L_SIGN: begin
        avg <= quot_signed[SAMPLE_BITS-1:0];
      end
      default: begin
      end
    endcase
  end

  assign status.busy = (state != L_IDLE);
  assign status.done = (state == L_DONE);

endmodule

[test/moving_average_three_axis_test.sv]
module moving_average_three_axis_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mavg_pkg::*;

  localparam int CLK_PERIOD  = 12;
  localparam int RESET_TICKS = 8;
  localparam int SETTLE      = 32;       // a little beyond the block's latency
  localparam int LIMIT       = 1000000;  // several times the slowest legal run
  localparam int ITEM_BUDGET = 1000;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef struct {
    sample_t x;
    sample_t y;
    sample_t z;
  } axis_word_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cfg_wr_en = 1'b0;
  logic [WINDOW_REG_BITS-1:0] cfg_wr_data = '0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  sample_t                    sample_x = '0;
  sample_t                    sample_y = '0;
  sample_t                    sample_z = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  sample_t                    avg_x;
  sample_t                    avg_y;
  sample_t                    avg_z;

  moving_average_three_axis u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .sample_x    (sample_x),
    .sample_y    (sample_y),
    .sample_z    (sample_z),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .avg_x       (avg_x),
    .avg_y       (avg_y),
    .avg_z       (avg_z)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // averaging predictor: own copy of the ring, write position and window
  // ---------------------------------------------------------------------------
  sample_t    ring_x [MAX_WINDOW];
  sample_t    ring_y [MAX_WINDOW];
  sample_t    ring_z [MAX_WINDOW];
  int         wr_pos;
  int         window;
  axis_word_t avg_expected [$];

  int err_count   = 0;
  int cycle_count = 0;
  int items_sent  = 0;
  bit rx_quiet    = 1'b0;   // receiver never stalls while set
  bit tx_quiet    = 1'b0;   // sender_gap never pauses while set

  function automatic void clear_history();
    for (int i = 0; i < MAX_WINDOW; i++) begin
      ring_x[i] = '0;
      ring_y[i] = '0;
      ring_z[i] = '0;
    end
    wr_pos = 0;
  endfunction

  // register value to window length: zero reads as one, large values clip to the ring size
  function automatic int clamp_window(logic [WINDOW_REG_BITS-1:0] v);
    if (v == 0)
      return 1;
    if (int'(v) > MAX_WINDOW)
      return MAX_WINDOW;
    return int'(v);
  endfunction

  // store the sample, then average ring entries 0 .. window-1 per axis
  function automatic axis_word_t predict_average(sample_t x, sample_t y, sample_t z);
    axis_word_t r;
    longint     sx;
    longint     sy;
    longint     sz;
    sx = 0;
    sy = 0;
    sz = 0;
    ring_x[wr_pos] = x;
    ring_y[wr_pos] = y;
    ring_z[wr_pos] = z;
    for (int i = 0; i < window; i++) begin
      sx += longint'(ring_x[i]);
      sy += longint'(ring_y[i]);
      sz += longint'(ring_z[i]);
    end
    // signed division truncates toward zero, as the block must
    r.x = sample_t'(sx / longint'(window));
    r.y = sample_t'(sy / longint'(window));
    r.z = sample_t'(sz / longint'(window));
    wr_pos = (wr_pos + 1 >= window) ? 0 : wr_pos + 1;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // result checker: every accepted output word against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    axis_word_t want;
    if (!rst && out_valid && !out_stall) begin
      if (avg_expected.size() == 0) begin
        $error("output word with nothing expected: avg_x %0d avg_y %0d avg_z %0d",
               avg_x, avg_y, avg_z);
        err_count++;
      end else begin
        want = avg_expected.pop_front();
        if (avg_x !== want.x) begin
          $error("avg_x mismatch: expected %0d, got %0d", want.x, avg_x);
          err_count++;
        end
        if (avg_y !== want.y) begin
          $error("avg_y mismatch: expected %0d, got %0d", want.y, avg_y);
          err_count++;
        end
        if (avg_z !== want.z) begin
          $error("avg_z mismatch: expected %0d, got %0d", want.z, avg_z);
          err_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("** moving_average_three_axis: FAILED **");
      $finish;
    end
  end

  // receiver back-pressure: free runs, then mostly short stalls and a few long ones
  initial begin : rx_stall_gen
    int run;
    forever begin
      run = $urandom_range(1, 40);
      repeat (run) begin
        @(posedge clk);
        out_stall <= 1'b0;
      end
      if (!rx_quiet) begin
        run = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 90) : $urandom_range(1, 4);
        repeat (run) begin
          @(posedge clk);
          out_stall <= !rx_quiet;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------------------

  // present one word and hold it until taken; valid is left high for a follow-on word
  task automatic send_sample(sample_t x, sample_t y, sample_t z);
    in_valid <= 1'b1;
    sample_x <= x;
    sample_y <= y;
    sample_z <= z;
    do
      @(posedge clk);
    while (in_stall);
    avg_expected.push_back(predict_average(x, y, z));
    items_sent++;
  endtask

  // random gap after a word: mostly none, some short, a few long
  task automatic sender_gap();
    int r;
    int n;
    r = $urandom_range(0, 99);
    if (tx_quiet || r < 60)
      n = 0;
    else if (r < 92)
      n = $urandom_range(1, 3);
    else
      n = $urandom_range(10, 60);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // stop sending and wait for every expected word, then let the lanes settle
  task automatic drain_averages();
    in_valid <= 1'b0;
    while (avg_expected.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // window write, only ever issued with the block idle
  task automatic set_window(logic [WINDOW_REG_BITS-1:0] v);
    drain_averages();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    window = clamp_window(v);
    clear_history();
    @(posedge clk);
  endtask

  function automatic sample_t pick_extreme();
    case ($urandom_range(0, 5))
      0:       return sample_t'(-32768);
      1:       return sample_t'(32767);
      2:       return sample_t'(-1);
      3:       return sample_t'(1);
      4:       return sample_t'(0);
      default: return sample_t'(-32767);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset window of eight, full-scale and sign-boundary samples
  task automatic test_reset_window();
    send_sample(16'sd32767, -16'sd32768, 16'sd0);
    send_sample(16'sd32767, -16'sd32768, -16'sd1);
    sender_gap();
    send_sample(-16'sd1, 16'sd1, -16'sd7);
    send_sample(-16'sd32768, 16'sd32767, 16'sd12345);
    send_sample(16'sh5555, 16'shaaaa, 16'sh7ffe);
    send_sample(16'shaaaa, 16'sh5555, 16'sh8001);
    sender_gap();
    send_sample(16'sd0, 16'sd0, 16'sd0);
    send_sample(-16'sd7, 16'sd7, -16'sd32768);
    drain_averages();
  endtask

  // window register extremes: zero saturates to one, above 64 clips to 64
  task automatic test_window_limits();
    set_window(7'd0);
    send_sample(-16'sd32768, 16'sd32767, -16'sd1);
    send_sample(16'sd32767, -16'sd32768, 16'sd1);
    set_window(7'd127);
    send_sample(-16'sd1, 16'sd1, -16'sd32768);    // tiny negative sum truncates to zero
    send_sample(-16'sd32768, 16'sd32767, -16'sd32768);
    set_window(7'd65);
    send_sample(16'sd32767, -16'sd63, 16'sd64);
    set_window(7'd64);
    send_sample(-16'sd64, 16'sd63, -16'sd65);
    set_window(7'd2);
    send_sample(-16'sd1, -16'sd1, 16'sd1);
    send_sample(-16'sd2, 16'sd3, -16'sd32768);
    send_sample(-16'sd32768, -16'sd32768, 16'sd32767);
    send_sample(16'sd5, -16'sd5, -16'sd32768);
  endtask

  // phases of random windows; content is uniform, edge-heavy or a held edge-value level
  task automatic test_random_phases();
    logic [WINDOW_REG_BITS-1:0] wv;
    int      count;
    int      mode;
    sample_t hold_x;
    sample_t hold_y;
    sample_t hold_z;
    sample_t x;
    sample_t y;
    sample_t z;
    while (items_sent < ITEM_BUDGET) begin
      case ($urandom_range(0, 7))
        0:       wv = 7'd0;
        1:       wv = 7'd1;
        2:       wv = 7'd64;
        3:       wv = 7'd127;
        4:       wv = 7'd65;
        default: wv = WINDOW_REG_BITS'($urandom_range(0, 127));
      endcase
      set_window(wv);
      mode   = $urandom_range(0, 2);
      hold_x = pick_extreme();
      hold_y = pick_extreme();
      hold_z = pick_extreme();
      // stretches with no random idling on either side
      tx_quiet = ($urandom_range(0, 4) == 0);
      rx_quiet = ($urandom_range(0, 4) == 0);
      count = window + $urandom_range(10, 60);
      repeat (count) begin
        x = sample_t'($urandom);
        y = sample_t'($urandom);
        z = sample_t'($urandom);
        if (mode == 1) begin
          if ($urandom_range(0, 2) == 0) x = pick_extreme();
          if ($urandom_range(0, 2) == 0) y = pick_extreme();
          if ($urandom_range(0, 2) == 0) z = pick_extreme();
        end else if (mode == 2 && $urandom_range(0, 9) != 0) begin
          // held edge-value level fills the window
          x = hold_x;
          y = hold_y;
          z = hold_z;
        end
        send_sample(x, y, z);
        if ($urandom_range(0, 149) == 0)
          drain_averages();   // sender holds off until every word is back
        else
          sender_gap();
      end
      tx_quiet = 1'b0;
      rx_quiet = 1'b0;
    end
  endtask

  initial begin
    window = clamp_window(WINDOW_REG_BITS'(WINDOW_RESET));
    clear_history();
    repeat (RESET_TICKS) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_window();
    test_window_limits();
    test_random_phases();
    drain_averages();

    if (err_count == 0 && avg_expected.size() == 0)
      $display("** moving_average_three_axis: PASSED **");
    else
      $display("** moving_average_three_axis: FAILED **");
    $finish;
  end

endmodule
